/* sv/mgs_pkg.sv */
// Shared constants, codes and types of the masked grid smoothing block.
package mgs_pkg;

  localparam int MAX_COLS   = 64;
  localparam int MAX_ROWS   = 64;
  localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int CELL_W     = $clog2(CELL_COUNT);

  localparam int KIND_W     = 2;
  localparam int COORD_W    = 6;
  localparam int VALUE_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam int ACC_W      = 37;
  localparam int WT_W       = 5;
  localparam int DIV_W      = WT_W + 1;
  localparam int DIV_STEPS  = ACC_W;
  localparam int CNT_W      = $clog2(DIV_STEPS + 1);
  localparam int TAPS       = 9;
  localparam int TAP_W      = $clog2(TAPS + 1);

  localparam logic [KIND_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] REQ_PASS  = 2'd1;
  localparam logic [KIND_W-1:0] REQ_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

  localparam logic [1:0] TAP_LO  = 2'd0;
  localparam logic [1:0] TAP_MID = 2'd1;
  localparam logic [1:0] TAP_HI  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DONE,
    S_P_CTR,
    S_P_CHK,
    S_P_TAP,
    S_P_PREP,
    S_P_DIV,
    S_P_WR
  } mgs_state_e;

endpackage

/* sv/mgs_intf.sv */
// Handshake interfaces for the request, response and configuration channels.
interface mgs_req_if;
  logic                               valid;
  logic                               ready;
  logic        [mgs_pkg::KIND_W-1:0]  req_type;
  logic        [mgs_pkg::COORD_W-1:0] col;
  logic        [mgs_pkg::COORD_W-1:0] row;
  logic signed [mgs_pkg::VALUE_W-1:0] cell_value;
  logic                               cell_solid;

  modport source (output valid, req_type, col, row, cell_value, cell_solid, input ready);
  modport sink (input valid, req_type, col, row, cell_value, cell_solid, output ready);
endinterface

interface mgs_rsp_if;
  logic                               valid;
  logic                               ready;
  logic        [mgs_pkg::KIND_W-1:0]  done_kind;
  logic signed [mgs_pkg::VALUE_W-1:0] read_value;
  logic                               read_solid;

  modport source (output valid, done_kind, read_value, read_solid, input ready);
  modport sink (input valid, done_kind, read_value, read_solid, output ready);
endinterface

interface mgs_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mgs_pkg::CFG_IDX_W-1:0]       reg_index;
  logic [mgs_pkg::CFG_DATA_W-1:0]      wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

/* sv/masked_grid_smoothing_core.sv */
// Top level of the masked grid smoothing block: grid store, smoothing sequencer and divider.
//
// The block keeps two banks of grid values in one simple dual-port RAM and the solid flags
// in a second RAM, both with a registered read. A write or read request is accepted only
// while the sequencer is idle; the sequencer then waits in its done state until the output
// register is free and loads the response into it, and only then accepts the next request;
// a new request is accepted while an earlier response still waits there.
// A smoothing pass walks all MAX_COLS x MAX_ROWS cells through the single read port: a cell
// outside the active grid or a solid cell goes through the center read and check states and
// is copied, while an active fluid cell goes on to its center and neighbor reads, the
// bit-serial rounding divider and one write of the result. A pass reads the current bank
// and writes the other one, so the read and write ports never touch the same entry; the
// bank flips when the pass ends.
module masked_grid_smoothing_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  mgs_req_if.sink    req_i,
  mgs_rsp_if.source  rsp_o,
  mgs_cfg_if.sink    cfg_i
);

  mgs_pkg::mgs_state_e state_q, state_d;

  logic                               bank_q, bank_d;
  logic [mgs_pkg::CFG_DATA_W-1:0]     grid_width_q, grid_width_d;
  logic [mgs_pkg::CFG_DATA_W-1:0]     grid_height_q, grid_height_d;
  logic [mgs_pkg::COL_W:0]            eff_w;
  logic [mgs_pkg::ROW_W:0]            eff_h;

  logic [mgs_pkg::KIND_W-1:0]         pend_kind_q, pend_kind_d;
  logic                               pend_inside_q, pend_inside_d;

  logic [mgs_pkg::ROW_W-1:0]          cell_r_q, cell_r_d;
  logic [mgs_pkg::COL_W-1:0]          cell_c_q, cell_c_d;
  logic [mgs_pkg::TAP_W-1:0]          tap_k_q, tap_k_d;
  logic [1:0]                         tap_r_q, tap_r_d;
  logic [1:0]                         tap_c_q, tap_c_d;
  logic [1:0]                         tap_sh_q, tap_sh_d;
  logic signed [mgs_pkg::ACC_W-1:0]   acc_q, acc_d;
  logic [mgs_pkg::WT_W-1:0]           wtot_q, wtot_d;
  logic [mgs_pkg::VALUE_W-1:0]        ctr_val_q, ctr_val_d;

  logic                               neg_q, neg_d;
  logic [mgs_pkg::DIV_W-1:0]          div_q, div_d;
  logic [mgs_pkg::ACC_W-1:0]          dv_nq_q, dv_nq_d;
  logic [mgs_pkg::DIV_W-1:0]          dv_rem_q, dv_rem_d;
  logic [mgs_pkg::CNT_W-1:0]          dv_cnt_q, dv_cnt_d;

  logic                               out_valid_q, out_valid_d;
  logic [mgs_pkg::KIND_W-1:0]         out_kind_q, out_kind_d;
  logic [mgs_pkg::VALUE_W-1:0]        out_value_q, out_value_d;
  logic                               out_solid_q, out_solid_d;

  logic [mgs_pkg::VALUE_W-1:0]        val_mem [2*mgs_pkg::CELL_COUNT];
  logic                               solid_mem [mgs_pkg::CELL_COUNT];
  logic                               val_we, val_re, sol_we;
  logic [mgs_pkg::CELL_W:0]           val_waddr, val_raddr;
  logic [mgs_pkg::CELL_W-1:0]         wr_cell, rd_cell;
  logic                               wr_bank;
  logic [mgs_pkg::VALUE_W-1:0]        val_wdata;
  logic [mgs_pkg::VALUE_W-1:0]        val_rdata_q;
  logic                               sol_rdata_q;

  logic                               req_inside;
  logic [mgs_pkg::CELL_W-1:0]         req_cell, cur_cell;
  logic [mgs_pkg::ROW_W-1:0]          nb_r;
  logic [mgs_pkg::COL_W-1:0]          nb_c;
  logic                               cell_active, last_cell, cell_done;
  logic signed [mgs_pkg::ACC_W-1:0]   tap_term;
  logic [mgs_pkg::WT_W-1:0]           tap_wt;
  logic [mgs_pkg::ACC_W-1:0]          acc_mag, div_num;
  logic [mgs_pkg::DIV_W:0]            rem_sh, rem_sub;
  logic                               rem_ge;
  logic [mgs_pkg::VALUE_W-1:0]        res_val;

  function automatic logic [mgs_pkg::CELL_W-1:0] cell_addr(
    input logic [mgs_pkg::ROW_W-1:0] r,
    input logic [mgs_pkg::COL_W-1:0] c
  );
    return mgs_pkg::CELL_W'(r) * mgs_pkg::CELL_W'(mgs_pkg::MAX_COLS) + mgs_pkg::CELL_W'(c);
  endfunction

  // Out-of-range register values act as the nearest legal grid size.
  always_comb begin
    if (grid_width_q == '0) begin
      eff_w = (mgs_pkg::COL_W+1)'(1);
    end else if (32'(grid_width_q) > mgs_pkg::MAX_COLS) begin
      eff_w = (mgs_pkg::COL_W+1)'(mgs_pkg::MAX_COLS);
    end else begin
      eff_w = (mgs_pkg::COL_W+1)'(grid_width_q);
    end
    if (grid_height_q == '0) begin
      eff_h = (mgs_pkg::ROW_W+1)'(1);
    end else if (32'(grid_height_q) > mgs_pkg::MAX_ROWS) begin
      eff_h = (mgs_pkg::ROW_W+1)'(mgs_pkg::MAX_ROWS);
    end else begin
      eff_h = (mgs_pkg::ROW_W+1)'(grid_height_q);
    end
  end

  assign req_inside = (32'(req_i.col) < mgs_pkg::MAX_COLS) &&
                      (32'(req_i.row) < mgs_pkg::MAX_ROWS);
  assign req_cell   = req_inside ? cell_addr(mgs_pkg::ROW_W'(req_i.row),
                                             mgs_pkg::COL_W'(req_i.col)) : '0;
  assign cur_cell   = cell_addr(cell_r_q, cell_c_q);

  assign cell_active = ({1'b0, cell_r_q} < eff_h) && ({1'b0, cell_c_q} < eff_w);
  assign last_cell   = (cell_r_q == mgs_pkg::ROW_W'(mgs_pkg::MAX_ROWS - 1)) &&
                       (cell_c_q == mgs_pkg::COL_W'(mgs_pkg::MAX_COLS - 1));

  // Neighbor coordinates are clamped to the active grid.
  always_comb begin
    case (tap_r_q)
      mgs_pkg::TAP_LO: nb_r = (cell_r_q == '0) ? cell_r_q : cell_r_q - 1'b1;
      mgs_pkg::TAP_HI: nb_r = ({1'b0, cell_r_q} + 1'b1 == eff_h) ? cell_r_q : cell_r_q + 1'b1;
      default:         nb_r = cell_r_q;
    endcase
    case (tap_c_q)
      mgs_pkg::TAP_LO: nb_c = (cell_c_q == '0) ? cell_c_q : cell_c_q - 1'b1;
      mgs_pkg::TAP_HI: nb_c = ({1'b0, cell_c_q} + 1'b1 == eff_w) ? cell_c_q : cell_c_q + 1'b1;
      default:         nb_c = cell_c_q;
    endcase
  end

  assign tap_term = {{(mgs_pkg::ACC_W - mgs_pkg::VALUE_W){val_rdata_q[mgs_pkg::VALUE_W-1]}},
                     val_rdata_q} << tap_sh_q;
  assign tap_wt   = mgs_pkg::WT_W'(1) << tap_sh_q;

  assign acc_mag = acc_q[mgs_pkg::ACC_W-1] ? mgs_pkg::ACC_W'(-acc_q) : mgs_pkg::ACC_W'(acc_q);
  assign div_num = (acc_mag << 1) + mgs_pkg::ACC_W'(wtot_q);

  assign rem_sh  = {dv_rem_q, dv_nq_q[mgs_pkg::ACC_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, div_q};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign res_val = neg_q ? -dv_nq_q[mgs_pkg::VALUE_W-1:0] : dv_nq_q[mgs_pkg::VALUE_W-1:0];

  assign val_waddr = {wr_bank, wr_cell};
  assign val_raddr = {bank_q, rd_cell};

  assign req_i.ready      = (state_q == mgs_pkg::S_IDLE);
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.done_kind  = out_kind_q;
  assign rsp_o.read_value = out_value_q;
  assign rsp_o.read_solid = out_solid_q;
  assign cfg_i.ready      = 1'b1;

  always_comb begin
    grid_width_d  = grid_width_q;
    grid_height_d = grid_height_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        mgs_pkg::CFG_GRID_WIDTH:  grid_width_d  = cfg_i.wdata;
        mgs_pkg::CFG_GRID_HEIGHT: grid_height_d = cfg_i.wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d       = state_q;
    bank_d        = bank_q;
    pend_kind_d   = pend_kind_q;
    pend_inside_d = pend_inside_q;
    cell_r_d      = cell_r_q;
    cell_c_d      = cell_c_q;
    tap_k_d       = tap_k_q;
    tap_r_d       = tap_r_q;
    tap_c_d       = tap_c_q;
    tap_sh_d      = tap_sh_q;
    acc_d         = acc_q;
    wtot_d        = wtot_q;
    ctr_val_d     = ctr_val_q;
    neg_d         = neg_q;
    div_d         = div_q;
    dv_nq_d       = dv_nq_q;
    dv_rem_d      = dv_rem_q;
    dv_cnt_d      = dv_cnt_q;
    out_valid_d   = out_valid_q && !rsp_o.ready;
    out_kind_d    = out_kind_q;
    out_value_d   = out_value_q;
    out_solid_d   = out_solid_q;
    val_we        = 1'b0;
    val_re        = 1'b0;
    sol_we        = 1'b0;
    wr_bank       = ~bank_q;
    wr_cell       = cur_cell;
    val_wdata     = val_rdata_q;
    rd_cell       = cur_cell;
    cell_done     = 1'b0;

    unique case (state_q)
      mgs_pkg::S_IDLE: begin
        if (req_i.valid) begin
          pend_kind_d   = req_i.req_type;
          pend_inside_d = req_inside;
          unique case (req_i.req_type)
            mgs_pkg::REQ_WRITE: begin
              val_we    = req_inside;
              sol_we    = req_inside;
              wr_bank   = bank_q;
              wr_cell   = req_cell;
              val_wdata = req_i.cell_value;
              state_d   = mgs_pkg::S_DONE;
            end
            mgs_pkg::REQ_READ: begin
              val_re  = 1'b1;
              rd_cell = req_cell;
              state_d = mgs_pkg::S_DONE;
            end
            mgs_pkg::REQ_PASS: begin
              cell_r_d = '0;
              cell_c_d = '0;
              state_d  = mgs_pkg::S_P_CTR;
            end
            default: ;
          endcase
        end
      end
      mgs_pkg::S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_kind_d  = pend_kind_q;
          if (pend_kind_q == mgs_pkg::REQ_READ && pend_inside_q) begin
            out_value_d = val_rdata_q;
            out_solid_d = sol_rdata_q;
          end else begin
            out_value_d = '0;
            out_solid_d = 1'b0;
          end
          state_d = mgs_pkg::S_IDLE;
        end
      end
      mgs_pkg::S_P_CTR: begin
        val_re  = 1'b1;
        state_d = mgs_pkg::S_P_CHK;
      end
      mgs_pkg::S_P_CHK: begin
        ctr_val_d = val_rdata_q;
        if (!cell_active || sol_rdata_q) begin
          val_we    = 1'b1;
          cell_done = 1'b1;
        end else begin
          tap_k_d = '0;
          tap_r_d = mgs_pkg::TAP_LO;
          tap_c_d = mgs_pkg::TAP_LO;
          acc_d   = '0;
          wtot_d  = '0;
          state_d = mgs_pkg::S_P_TAP;
        end
      end
      mgs_pkg::S_P_TAP: begin
        if (tap_k_q != mgs_pkg::TAP_W'(mgs_pkg::TAPS)) begin
          val_re   = 1'b1;
          rd_cell  = cell_addr(nb_r, nb_c);
          tap_sh_d = 2'(tap_r_q == mgs_pkg::TAP_MID) + 2'(tap_c_q == mgs_pkg::TAP_MID);
          if (tap_c_q == mgs_pkg::TAP_HI) begin
            tap_c_d = mgs_pkg::TAP_LO;
            tap_r_d = tap_r_q + 1'b1;
          end else begin
            tap_c_d = tap_c_q + 1'b1;
          end
        end else begin
          state_d = mgs_pkg::S_P_PREP;
        end
        if (tap_k_q != '0 && !sol_rdata_q) begin
          acc_d  = acc_q + tap_term;
          wtot_d = wtot_q + tap_wt;
        end
        tap_k_d = tap_k_q + 1'b1;
      end
      mgs_pkg::S_P_PREP: begin
        if (wtot_q == '0) begin
          val_we    = 1'b1;
          val_wdata = ctr_val_q;
          cell_done = 1'b1;
        end else begin
          neg_d    = acc_q[mgs_pkg::ACC_W-1];
          div_d    = {wtot_q, 1'b0};
          dv_nq_d  = div_num;
          dv_rem_d = '0;
          dv_cnt_d = '0;
          state_d  = mgs_pkg::S_P_DIV;
        end
      end
      mgs_pkg::S_P_DIV: begin
        dv_nq_d  = {dv_nq_q[mgs_pkg::ACC_W-2:0], rem_ge};
        dv_rem_d = rem_ge ? rem_sub[mgs_pkg::DIV_W-1:0] : rem_sh[mgs_pkg::DIV_W-1:0];
        dv_cnt_d = dv_cnt_q + 1'b1;
        if (dv_cnt_q == mgs_pkg::CNT_W'(mgs_pkg::DIV_STEPS - 1)) begin
          state_d = mgs_pkg::S_P_WR;
        end
      end
      mgs_pkg::S_P_WR: begin
        val_we    = 1'b1;
        val_wdata = res_val;
        cell_done = 1'b1;
      end
      default: state_d = mgs_pkg::S_IDLE;
    endcase

    if (cell_done) begin
      if (last_cell) begin
        bank_d  = ~bank_q;
        state_d = mgs_pkg::S_DONE;
      end else begin
        if (cell_c_q == mgs_pkg::COL_W'(mgs_pkg::MAX_COLS - 1)) begin
          cell_c_d = '0;
          cell_r_d = cell_r_q + 1'b1;
        end else begin
          cell_c_d = cell_c_q + 1'b1;
        end
        state_d = mgs_pkg::S_P_CTR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= mgs_pkg::S_IDLE;
      bank_q        <= 1'b0;
      grid_width_q  <= mgs_pkg::CFG_DATA_W'(mgs_pkg::MAX_COLS);
      grid_height_q <= mgs_pkg::CFG_DATA_W'(mgs_pkg::MAX_ROWS);
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      bank_q        <= bank_d;
      grid_width_q  <= grid_width_d;
      grid_height_q <= grid_height_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_kind_q   <= pend_kind_d;
    pend_inside_q <= pend_inside_d;
    cell_r_q      <= cell_r_d;
    cell_c_q      <= cell_c_d;
    tap_k_q       <= tap_k_d;
    tap_r_q       <= tap_r_d;
    tap_c_q       <= tap_c_d;
    tap_sh_q      <= tap_sh_d;
    acc_q         <= acc_d;
    wtot_q        <= wtot_d;
    ctr_val_q     <= ctr_val_d;
    neg_q         <= neg_d;
    div_q         <= div_d;
    dv_nq_q       <= dv_nq_d;
    dv_rem_q      <= dv_rem_d;
    dv_cnt_q      <= dv_cnt_d;
    out_kind_q    <= out_kind_d;
    out_value_q   <= out_value_d;
    out_solid_q   <= out_solid_d;
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_waddr] <= val_wdata;
    end
    if (val_re) begin
      val_rdata_q <= val_mem[val_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sol_we) begin
      solid_mem[wr_cell] <= req_i.cell_solid;
    end
    if (val_re) begin
      sol_rdata_q <= solid_mem[rd_cell];
    end
  end

`ifndef ASSERT_OFF
  a_bank_flip_at_pass_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(bank_q) |-> (state_q == mgs_pkg::S_DONE && pend_kind_q == mgs_pkg::REQ_PASS))
    else $error("Bank select changed outside the end of a smoothing pass.");

  a_pass_writes_other_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (val_we && state_q != mgs_pkg::S_IDLE) |-> (val_waddr[mgs_pkg::CELL_W] != bank_q))
    else $error("Smoothing pass wrote into the bank it reads from.");

  a_no_same_entry_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (val_we && val_re) |-> (val_waddr != val_raddr))
    else $error("Value RAM read and written at the same entry in one cycle.");

  a_div_remainder_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mgs_pkg::S_P_DIV) |-> (dv_rem_q < div_q))
    else $error("Divider partial remainder is not below the divisor.");
`endif

endmodule
